// ===== rtl/crn_pkg.sv =====
// Shared types and constants of the credit ring node.
package crn_pkg;

    localparam int NODE_W  = 4;
    localparam int RING_W  = 5;
    localparam int CRED_W  = 7;
    localparam int ROLL_W  = 16;
    localparam int RAND_W  = 32;
    localparam int ENTRY_W = 2 * NODE_W;
    localparam int MAX_NODES = 16;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_MSG    = 2'd1,
        ACT_CREDIT = 2'd2,
        ACT_START  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        PORT_NEXT     = 2'd0,
        PORT_PREV     = 2'd1,
        PORT_DEADLOCK = 2'd2
    } port_t;

    typedef enum logic [1:0] {
        CFG_OWN_NODE  = 2'd0,
        CFG_RING      = 2'd1,
        CFG_LIMIT     = 2'd2,
        CFG_THRESHOLD = 2'd3
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              busy;
        logic [NODE_W-1:0] value;
    } rem_status_t;

endpackage

// ===== rtl/crn_ram.sv =====
// Generic single-port-write, registered-read RAM.
module crn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/crn_rem.sv =====
// Iterative remainder of |operand| by the ring size, eight bits per cycle.
module crn_rem (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [crn_pkg::RAND_W-1:0] operand,
    input  logic [crn_pkg::RING_W-1:0]      ring,
    output crn_pkg::rem_status_t            status
);

    localparam int STEP_BITS = 8;
    localparam int STEPS     = crn_pkg::RAND_W / STEP_BITS;
    localparam int CNT_W     = $clog2(STEPS);

    logic [crn_pkg::RAND_W-1:0] mag_reg, mag_next;
    logic [crn_pkg::RING_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [crn_pkg::RAND_W-1:0] opnd_u;
    logic [crn_pkg::RING_W-1:0] part;

    assign opnd_u = operand;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        part      = rem_reg;
        if (start)
        begin
            mag_next  = opnd_u[crn_pkg::RAND_W-1] ? (~opnd_u + 1'b1) : opnd_u;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restoring steps over the top byte; partial stays below ring
            for (int i = 0; i < STEP_BITS; i++)
            begin
                part = {part[crn_pkg::RING_W-2:0], mag_reg[crn_pkg::RAND_W-1-i]};
                if (part >= ring)
                begin
                    part = part - ring;
                end
            end
            rem_next = part;
            mag_next = mag_reg << STEP_BITS;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
    end

    assign status.busy  = busy_reg;
    assign status.value = rem_reg[crn_pkg::NODE_W-1:0];

endmodule

// ===== rtl/credit_ring_node_deadlock_probe_unit.sv =====
// Top level of the credit ring node with deadlock probing.
// One input item is taken at a time. A credit arrival yields no result; a start
// or message arrival yields its results one after another, and a tick does so
// (up to three) once the remainder unit that finds the destination of a
// generated message is done; a held output item holds back the remaining
// results of the current item, and a new input item is taken once the last
// of them sits in the output register. The message queue
// lives in a RAM with registered read, addressed by the head pointer; all
// writes of one item land before the next item reads the head entry. No
// clearing pass is needed after reset.
module credit_ring_node_deadlock_probe_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // in_source[3:0], in_dest[7:4], in_status[8], in_kind[9], in_credits[16:10],
    // gen_roll[32:17], gen_random[64:33], zero[71:65]
    input  logic [71:0] s_tdata,
    // action[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_source[3:0], out_dest[7:4], out_status[8], out_kind[9],
    // out_credits[16:10], zero[23:17]
    output logic [23:0] m_tdata,
    // out_port[1:0]
    output logic [1:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CAP   = (QUEUE_DEPTH < 127) ? QUEUE_DEPTH : 127;
    localparam int CNT_W = $clog2(CAP + 1);
    localparam int NW    = crn_pkg::NODE_W;
    localparam int CW    = crn_pkg::CRED_W;
    localparam int RW    = crn_pkg::RING_W;

    // pending result bits, emitted lowest first
    localparam int P_PROBE = 0;
    localparam int P_MSG   = 1;
    localparam int P_CRED  = 2;

    // configuration
    logic [NW-1:0]               own_reg;
    logic [RW-1:0]               ring_reg;
    logic [CW-1:0]               limit_reg;
    logic [crn_pkg::ROLL_W-1:0]  thresh_reg;

    // queue and credit state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CW-1:0]    ncred_reg, ncred_next;

    // captured item
    crn_pkg::act_t              act_reg;
    logic [NW-1:0]              isrc_reg, idst_reg;
    logic                       ist_reg, ikind_reg;
    logic [CW-1:0]              icred_reg;
    logic [crn_pkg::ROLL_W-1:0] roll_reg;

    // sequencer
    crn_pkg::state_t state_reg, state_next;
    logic [2:0]      pend_reg, pend_next;
    crn_pkg::port_t  mport_reg, mport_next;
    logic [NW-1:0]   msrc_reg, msrc_next, mdst_reg, mdst_next;
    logic            mst_reg, mst_next, mkind_reg, mkind_next;

    // output register
    logic           ovalid_reg, ovalid_next;
    crn_pkg::port_t oport_reg, oport_next;
    logic [NW-1:0]  osrc_reg, osrc_next, odst_reg, odst_next;
    logic           ost_reg, ost_next, okind_reg, okind_next, olast_reg, olast_next;
    logic [CW-1:0]  ocred_reg, ocred_next;

    logic [RW-1:0]  ring_eff;
    logic [CW-1:0]  lim_eff;
    logic [CW-1:0]  free_cred;
    logic [NW-1:0]  nextn_reg;
    logic           accept;
    logic           ram_we;
    logic [crn_pkg::ENTRY_W-1:0] ram_rdata;
    logic [NW-1:0]  head_src, head_dst;
    logic [CW-1:0]  count_w;
    crn_pkg::rem_status_t rem_st;

    // remainder of a 5-bit value by a ring size of at least one
    function automatic logic [NW-1:0] small_mod(input logic [RW-1:0] a,
                                                input logic [RW-1:0] m);
        logic [RW-1:0] r;
        r = '0;
        for (int i = RW - 1; i >= 0; i--)
        begin
            r = {r[RW-2:0], a[i]};
            if (r >= m)
            begin
                r = r - m;
            end
        end
        return r[NW-1:0];
    endfunction

    assign ring_eff = (ring_reg == '0) ? RW'(1)
                    : (32'(ring_reg) > crn_pkg::MAX_NODES) ? RW'(crn_pkg::MAX_NODES)
                    : ring_reg;
    assign lim_eff  = (32'(limit_reg) > QUEUE_DEPTH) ? CW'(QUEUE_DEPTH) : limit_reg;
    assign count_w  = CW'(count_reg);
    assign free_cred = (count_w < lim_eff) ? (lim_eff - count_w) : '0;
    assign head_src = ram_rdata[NW-1:0];
    assign head_dst = ram_rdata[crn_pkg::ENTRY_W-1:NW];

    assign s_tready = (state_reg == crn_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    crn_ram #(
        .WIDTH (crn_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata ({idst_reg, isrc_reg}),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    crn_rem u_rem (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept && (crn_pkg::act_t'(s_tuser) == crn_pkg::ACT_TICK)),
        .operand (s_tdata[64:33]),
        .ring    (ring_eff),
        .status  (rem_st)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg    <= NW'(1);
            ring_reg   <= RW'(5);
            limit_reg  <= CW'(50);
            thresh_reg <= 16'd32768;
        end
        else if (cfg_we)
        begin
            unique case (crn_pkg::cfg_t'(cfg_index))
                crn_pkg::CFG_OWN_NODE:  own_reg    <= cfg_data[NW-1:0];
                crn_pkg::CFG_RING:      ring_reg   <= cfg_data[RW-1:0];
                crn_pkg::CFG_LIMIT:     limit_reg  <= cfg_data[CW-1:0];
                crn_pkg::CFG_THRESHOLD: thresh_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // next node is registered and follows the configuration in the cycle after it changes
    always_ff @(posedge clk)
    begin
        nextn_reg <= small_mod(RW'(own_reg) + RW'(1), ring_eff);
    end

    // capture the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= crn_pkg::act_t'(s_tuser);
            isrc_reg  <= s_tdata[3:0];
            idst_reg  <= s_tdata[7:4];
            ist_reg   <= s_tdata[8];
            ikind_reg <= s_tdata[9];
            icred_reg <= s_tdata[16:10];
            roll_reg  <= s_tdata[32:17];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        ncred_next  = ncred_reg;
        mport_next  = mport_reg;
        msrc_next   = msrc_reg;
        mdst_next   = mdst_reg;
        mst_next    = mst_reg;
        mkind_next  = mkind_reg;
        ovalid_next = ovalid_reg;
        oport_next  = oport_reg;
        osrc_next   = osrc_reg;
        odst_next   = odst_reg;
        ost_next    = ost_reg;
        okind_next  = okind_reg;
        ocred_next  = ocred_reg;
        olast_next  = olast_reg;
        ram_we      = 1'b0;

        // drop the output item once taken
        if (ovalid_reg && m_tready)
        begin
            ovalid_next = 1'b0;
        end

        unique case (state_reg)
            crn_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = crn_pkg::ST_CALC;
                end
            end
            crn_pkg::ST_CALC:
            begin
                if (!rem_st.busy)
                begin
                    pend_next = '0;
                    unique case (act_reg)
                        crn_pkg::ACT_TICK:
                        begin
                            if (ncred_reg == '0 && own_reg == '0)
                            begin
                                pend_next[P_PROBE] = 1'b1;
                            end
                            if (ncred_reg != '0 && roll_reg <= thresh_reg)
                            begin
                                pend_next[P_MSG] = 1'b1;
                                mport_next = crn_pkg::PORT_NEXT;
                                msrc_next  = own_reg;
                                mdst_next  = rem_st.value;
                                mst_next   = 1'b0;
                                mkind_next = 1'b0;
                            end
                            else if (count_reg != '0 &&
                                     (ncred_reg != '0 || head_dst == nextn_reg))
                            begin
                                // forward the head, then report credits
                                pend_next[P_MSG]  = 1'b1;
                                pend_next[P_CRED] = 1'b1;
                                mport_next = crn_pkg::PORT_NEXT;
                                msrc_next  = head_src;
                                mdst_next  = head_dst;
                                mst_next   = 1'b0;
                                mkind_next = 1'b0;
                                head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                             '0 : head_reg + 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        crn_pkg::ACT_MSG:
                        begin
                            mport_next = crn_pkg::PORT_NEXT;
                            msrc_next  = isrc_reg;
                            mdst_next  = idst_reg;
                            mst_next   = 1'b1;
                            mkind_next = 1'b1;
                            if (!ikind_reg)
                            begin
                                if (idst_reg != own_reg && count_w < lim_eff)
                                begin
                                    ram_we     = 1'b1;
                                    tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ?
                                                 '0 : tail_reg + 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                    pend_next[P_CRED] = 1'b1;
                                end
                            end
                            else if (isrc_reg == own_reg)
                            begin
                                if (ist_reg)
                                begin
                                    mport_next = crn_pkg::PORT_DEADLOCK;
                                    pend_next[P_MSG] = 1'b1;
                                end
                            end
                            else if (ist_reg && ncred_reg == '0 &&
                                     (count_reg == '0 || head_dst != nextn_reg))
                            begin
                                pend_next[P_MSG] = 1'b1;
                            end
                        end
                        crn_pkg::ACT_CREDIT:
                        begin
                            ncred_next = icred_reg;
                        end
                        crn_pkg::ACT_START:
                        begin
                            pend_next[P_CRED] = 1'b1;
                        end
                        default: ;
                    endcase
                    state_next = (pend_next == '0) ? crn_pkg::ST_IDLE : crn_pkg::ST_EMIT;
                end
            end
            crn_pkg::ST_EMIT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    ocred_next  = '0;
                    if (pend_reg[P_PROBE])
                    begin
                        oport_next = crn_pkg::PORT_NEXT;
                        osrc_next  = own_reg;
                        odst_next  = own_reg;
                        ost_next   = 1'b1;
                        okind_next = 1'b1;
                        pend_next  = pend_reg & ~3'b001;
                    end
                    else if (pend_reg[P_MSG])
                    begin
                        oport_next = mport_reg;
                        osrc_next  = msrc_reg;
                        odst_next  = mdst_reg;
                        ost_next   = mst_reg;
                        okind_next = mkind_reg;
                        pend_next  = pend_reg & ~3'b010;
                    end
                    else
                    begin
                        oport_next = crn_pkg::PORT_PREV;
                        osrc_next  = '0;
                        odst_next  = '0;
                        ost_next   = 1'b0;
                        okind_next = 1'b0;
                        ocred_next = free_cred;
                        pend_next  = '0;
                    end
                    olast_next = (pend_next == '0);
                    if (pend_next == '0)
                    begin
                        state_next = crn_pkg::ST_IDLE;
                    end
                end
            end
            default: state_next = crn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= crn_pkg::ST_IDLE;
            pend_reg   <= '0;
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            ncred_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pend_reg   <= pend_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            ncred_reg  <= ncred_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mport_reg <= mport_next;
        msrc_reg  <= msrc_next;
        mdst_reg  <= mdst_next;
        mst_reg   <= mst_next;
        mkind_reg <= mkind_next;
        oport_reg <= oport_next;
        osrc_reg  <= osrc_next;
        odst_reg  <= odst_next;
        ost_reg   <= ost_next;
        okind_reg <= okind_next;
        ocred_reg <= ocred_next;
        olast_reg <= olast_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {7'b0, ocred_reg, okind_reg, ost_reg, odst_reg, osrc_reg};
    assign m_tuser  = oport_reg;
    assign m_tlast  = olast_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= CAP)
        else $error("queue count beyond capacity");

    a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (count_w < lim_eff))
        else $error("queue write with no room");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with pointers apart");

    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == crn_pkg::ST_IDLE) |-> (pend_reg == '0))
        else $error("results pending while idle");

    a_ram_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !ram_we)
        else $error("queue write in the head read cycle");

endmodule
